### rtl/core/dbf_pkg.sv
// Shared constants and types for the duplicate-rejecting bounded FIFO.
// No dependencies; used by dbf_key_ram and dedup_bounded_fifo.
`default_nettype none

package dbf_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned KEY_W     = 16;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned FILL_W    = 5;
	localparam int unsigned STAT_W    = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

endpackage

`default_nettype wire

### rtl/core/dbf_key_ram.sv
// Key store: one write port, one read port with registered read data.
// Depends on dbf_pkg for the key width.
`default_nettype none

module dbf_key_ram #(
	parameter int unsigned DEPTH = dbf_pkg::DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire  [AW-1:0]                 wr_addr,
	input  wire  [dbf_pkg::KEY_W-1:0]     wr_data,
	input  wire  [AW-1:0]                 rd_addr,
	output logic [dbf_pkg::KEY_W-1:0]     rd_data
);

	logic [dbf_pkg::KEY_W-1:0] mem [DEPTH];
	logic [dbf_pkg::KEY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/dedup_bounded_fifo.sv
// Bounded FIFO of keys that refuses duplicate pushes; top level.
// Depends on dbf_pkg and dbf_key_ram (key store with registered read).
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, req_type, item_key      into block
//   out      out_valid/out_ready, status, popped_key,   out of block
//            fill_count, head_key
//   cfg      cfg_wr_en, cfg_wr_data (capacity)          into block
//
// A push walks the held keys through the single compare unit, one key a
// cycle from the key store read port. Push states: CHECK, SCAN, APPEND,
// DONE; pop: CHECK, POPLD, DONE; refused push or empty pop: CHECK, DONE.
// A duplicate ends the walk early. in_ready is high only while idle.
// The result register lets the next item in while a result waits; the block
// stalls in its last step only if that register is still full.
// Reset clears pointer, count and head; the key store is not cleared.
`default_nettype none

module dedup_bounded_fifo #(
	parameter int unsigned DEPTH = dbf_pkg::DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            req_type,
	input  wire  [dbf_pkg::KEY_W-1:0]      item_key,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [dbf_pkg::STAT_W-1:0]     status,
	output logic [dbf_pkg::KEY_W-1:0]      popped_key,
	output logic [dbf_pkg::FILL_W-1:0]     fill_count,
	output logic [dbf_pkg::KEY_W-1:0]      head_key,
	input  wire                            cfg_wr_en,
	input  wire  [dbf_pkg::CAP_W-1:0]      cfg_wr_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (CW > dbf_pkg::FILL_W) ? CW : dbf_pkg::FILL_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CHECK  = 6'b000010,
		S_SCAN   = 6'b000100,
		S_APPEND = 6'b001000,
		S_POPLD  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                      state_q;
	logic [dbf_pkg::CAP_W-1:0]   cap_q;
	logic [AW-1:0]               rp_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               idx_q;
	logic                        pend_q;
	logic                        req_q;
	logic [dbf_pkg::KEY_W-1:0]   key_q;
	logic [dbf_pkg::KEY_W-1:0]   head_q;
	logic [dbf_pkg::KEY_W-1:0]   pop_q;
	dbf_pkg::status_t            stat_q;

	logic                        out_valid_q;
	dbf_pkg::status_t            out_stat_q;
	logic [dbf_pkg::KEY_W-1:0]   out_pop_q;
	logic [dbf_pkg::FILL_W-1:0]  out_fill_q;
	logic [dbf_pkg::KEY_W-1:0]   out_head_q;

	logic                        in_fire;
	logic                        out_load;
	logic                        full;
	logic [LW-1:0]               cap_ext;
	logic [LW-1:0]               limit;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [AW-1:0]               ram_raddr;
	logic [dbf_pkg::KEY_W-1:0]   ram_rdata;

	// (base + off) mod DEPTH, with off never above DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign cap_ext = LW'(cap_q);
	assign limit   = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
	assign full    = (LW'(count_q) >= limit);

	assign ram_we    = (state_q == S_APPEND);
	assign ram_waddr = slot(rp_q, count_q);

	always_comb begin
		case (state_q)
			S_CHECK: ram_raddr = inc_ptr(rp_q);
			default: ram_raddr = slot(rp_q, idx_q);
		endcase
	end

	dbf_key_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (key_q),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dbf_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// payload holding registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= req_type;
			key_q <= item_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rp_q    <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			head_q  <= '0;
			pop_q   <= '0;
			stat_q  <= dbf_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					if (req_q == dbf_pkg::REQ_PUSH) begin
						pop_q <= '0;
						if (full) begin
							stat_q  <= dbf_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (count_q == '0) begin
						pop_q   <= '0;
						stat_q  <= dbf_pkg::ST_EMPTY;
						state_q <= S_DONE;
					end else begin
						// read of the next head is issued this cycle
						stat_q  <= dbf_pkg::ST_OK;
						pop_q   <= head_q;
						rp_q    <= inc_ptr(rp_q);
						count_q <= count_q - CW'(1);
						state_q <= S_POPLD;
					end
				end
				S_SCAN: begin
					// compare the key read last cycle, issue the next read
					if (pend_q && (ram_rdata == key_q)) begin
						stat_q  <= dbf_pkg::ST_DUP;
						state_q <= S_DONE;
					end else if (idx_q < count_q) begin
						idx_q  <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					stat_q  <= dbf_pkg::ST_OK;
					count_q <= count_q + CW'(1);
					if (count_q == '0) begin
						head_q <= key_q;
					end
					state_q <= S_DONE;
				end
				S_POPLD: begin
					head_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stat_q <= stat_q;
			out_pop_q  <= pop_q;
			out_fill_q <= dbf_pkg::FILL_W'(LW'(count_q));
			out_head_q <= (count_q == '0) ? '0 : head_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_stat_q;
	assign popped_key = out_pop_q;
	assign fill_count = out_fill_q;
	assign head_key   = out_head_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the fill count");

	a_rp_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!((state_q == S_CHECK) && (req_q == dbf_pkg::REQ_POP) && (count_q != '0))
		|=> (rp_q == $past(rp_q)))
		else $error("read pointer moved without a pop");

	a_dup_needs_keys: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (stat_q == dbf_pkg::ST_DUP)) |-> (count_q != '0))
		else $error("duplicate reported on an empty queue");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !in_ready)
		else $error("input ready during key scan");

endmodule

`default_nettype wire

### bench/dedup_bounded_fifo_test.sv
// Self-checking bench for dedup_bounded_fifo: directed table, then random phases.
// Depends on dbf_pkg and the dedup_bounded_fifo RTL; predicts each response in-line.
`timescale 1ns / 100ps

module dedup_bounded_fifo_test;
	import dbf_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	localparam int unsigned QUIET = DEPTH + 8;
	localparam int unsigned LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASES = 14;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned N_ROWS = 24;

	typedef struct {
		status_t          st;
		logic [KEY_W-1:0] popped;
		logic [FILL_W-1:0] fill;
		logic [KEY_W-1:0] head;
	} response_t;

	typedef struct {
		bit                set_cap;
		logic [CAP_W-1:0]  cap;
		logic              rq;
		logic [KEY_W-1:0]  key;
		bit                typed;
		status_t           st;
		logic [KEY_W-1:0]  popped;
		logic [FILL_W-1:0] fill;
		logic [KEY_W-1:0]  head;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [KEY_W-1:0] item_key;
	logic out_valid;
	logic out_ready;
	logic [STAT_W-1:0] status;
	logic [KEY_W-1:0] popped_key;
	logic [FILL_W-1:0] fill_count;
	logic [KEY_W-1:0] head_key;
	logic cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;

	// shadow of the queue
	logic [KEY_W-1:0] shadow_keys [DEPTH];
	int unsigned shadow_head;
	int unsigned shadow_fill;
	logic [CAP_W-1:0] shadow_cap;

	response_t awaited_responses [$];
	response_t due;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit calm;
	bit stall_now;

	int unsigned cap_plan [9] = '{31, 5, 16, 0, 1, 2, 16, 24, 8};

	script_row_t script [N_ROWS] = '{
		'{1'b0, 5'd0,  REQ_POP,  16'h0000, 1'b1, ST_EMPTY, 16'h0000, 5'd0, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h0000, 1'b1, ST_OK,    16'h0000, 5'd1, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h0000, 1'b1, ST_DUP,   16'h0000, 5'd1, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'hFFFF, 1'b1, ST_OK,    16'h0000, 5'd2, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h5A5A, 1'b1, ST_OK,    16'h0000, 5'd3, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'hFFFF, 1'b1, ST_DUP,   16'h0000, 5'd3, 16'h0000},
		// capacity dropped below the fill
		'{1'b1, 5'd2,  REQ_PUSH, 16'h0001, 1'b1, ST_FULL,  16'h0000, 5'd3, 16'h0000},
		'{1'b0, 5'd0,  REQ_POP,  16'hFFFF, 1'b1, ST_OK,    16'h0000, 5'd2, 16'hFFFF},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h0001, 1'b1, ST_FULL,  16'h0000, 5'd2, 16'hFFFF},
		'{1'b0, 5'd0,  REQ_POP,  16'h0000, 1'b1, ST_OK,    16'hFFFF, 5'd1, 16'h5A5A},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h5A5A, 1'b1, ST_DUP,   16'h0000, 5'd1, 16'h5A5A},
		'{1'b0, 5'd0,  REQ_PUSH, 16'hA5A5, 1'b1, ST_OK,    16'h0000, 5'd2, 16'h5A5A},
		// full and duplicate at once: full wins
		'{1'b0, 5'd0,  REQ_PUSH, 16'h5A5A, 1'b1, ST_FULL,  16'h0000, 5'd2, 16'h5A5A},
		'{1'b1, 5'd0,  REQ_PUSH, 16'h0007, 1'b1, ST_FULL,  16'h0000, 5'd2, 16'h5A5A},
		'{1'b0, 5'd0,  REQ_POP,  16'h0000, 1'b1, ST_OK,    16'h5A5A, 5'd1, 16'hA5A5},
		'{1'b0, 5'd0,  REQ_POP,  16'h0000, 1'b1, ST_OK,    16'hA5A5, 5'd0, 16'h0000},
		'{1'b0, 5'd0,  REQ_POP,  16'hFFFF, 1'b1, ST_EMPTY, 16'h0000, 5'd0, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h0003, 1'b1, ST_FULL,  16'h0000, 5'd0, 16'h0000},
		'{1'b1, 5'd31, REQ_PUSH, 16'h1234, 1'b1, ST_OK,    16'h0000, 5'd1, 16'h1234},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h1234, 1'b1, ST_DUP,   16'h0000, 5'd1, 16'h1234},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h8001, 1'b0, ST_OK,    16'h0000, 5'd0, 16'h0000},
		'{1'b0, 5'd0,  REQ_PUSH, 16'h7FFE, 1'b0, ST_OK,    16'h0000, 5'd0, 16'h0000},
		'{1'b0, 5'd0,  REQ_POP,  16'h0000, 1'b0, ST_OK,    16'h0000, 5'd0, 16'h0000},
		'{1'b1, 5'd17, REQ_PUSH, 16'hFFFF, 1'b0, ST_OK,    16'h0000, 5'd0, 16'h0000}
	};

	dedup_bounded_fifo uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.item_key   (item_key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.popped_key (popped_key),
		.fill_count (fill_count),
		.head_key   (head_key),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic response_t predict_response(logic rq, logic [KEY_W-1:0] k);
		response_t r;
		int unsigned lim;
		bit seen;
		r.st = ST_OK;
		r.popped = '0;
		lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
		seen = 1'b0;
		if (rq == REQ_PUSH) begin
			for (int unsigned i = 0; i < shadow_fill; i++)
				if (shadow_keys[(shadow_head + i) % DEPTH] == k)
					seen = 1'b1;
			if (shadow_fill >= lim) begin
				r.st = ST_FULL;
			end else if (seen) begin
				r.st = ST_DUP;
			end else begin
				shadow_keys[(shadow_head + shadow_fill) % DEPTH] = k;
				shadow_fill++;
			end
		end else if (shadow_fill == 0) begin
			r.st = ST_EMPTY;
		end else begin
			r.popped = shadow_keys[shadow_head];
			shadow_head = (shadow_head + 1) % DEPTH;
			shadow_fill--;
		end
		r.fill = FILL_W'(shadow_fill);
		r.head = (shadow_fill == 0) ? '0 : shadow_keys[shadow_head];
		return r;
	endfunction

	// mostly a small pool so duplicates are common; some held keys, some wide keys
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 20 && shadow_fill > 0)
			return shadow_keys[(shadow_head + $urandom_range(shadow_fill - 1)) % DEPTH];
		if (roll < 65)
			return KEY_W'($urandom_range(23));
		if (roll < 70)
			return ($urandom_range(1) == 0) ? '0 : '1;
		return KEY_W'($urandom);
	endfunction

	// returns at the rising edge where the item is taken
	task automatic offer_item(input logic rq, input logic [KEY_W-1:0] k);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		item_key <= k;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		shadow_cap = v;
	endtask

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_now) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				stall_now = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_responses.size() == 0) begin
				$error("result with nothing outstanding: status %0d popped %h", status,
					popped_key);
				mismatches++;
			end else begin
				due = awaited_responses.pop_front();
				if (status !== due.st) begin
					$error("status: expected %0d, got %0d", due.st, status);
					mismatches++;
				end
				if (popped_key !== due.popped) begin
					$error("popped_key: expected %h, got %h", due.popped, popped_key);
					mismatches++;
				end
				if (fill_count !== due.fill) begin
					$error("fill_count: expected %0d, got %0d", due.fill, fill_count);
					mismatches++;
				end
				if (head_key !== due.head) begin
					$error("head_key: expected %h, got %h", due.head, head_key);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		response_t got;
		response_t typed_resp;
		int unsigned push_pct;
		logic rq;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PUSH;
		item_key = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		calm = 1'b0;
		stall_now = 1'b0;
		shadow_cap = CAP_RESET;
		shadow_head = 0;
		shadow_fill = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].set_cap)
				set_capacity(script[i].cap);
			offer_item(script[i].rq, script[i].key);
			got = predict_response(script[i].rq, script[i].key);
			if (script[i].typed) begin
				typed_resp.st = script[i].st;
				typed_resp.popped = script[i].popped;
				typed_resp.fill = script[i].fill;
				typed_resp.head = script[i].head;
				awaited_responses.push_back(typed_resp);
			end else begin
				awaited_responses.push_back(got);
			end
		end

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			set_capacity(phase < 9 ? CAP_W'(cap_plan[phase]) : CAP_W'($urandom_range(31)));
			calm = (phase == 6);
			// hold the output off while items keep coming, so the input stalls
			if (phase == 1)
				stall_now = 1'b1;
			push_pct = $urandom_range(40, 75);
			repeat (PHASE_ITEMS) begin
				rq = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
				offer_item(rq, (rq == REQ_PUSH) ? pick_key() : KEY_W'($urandom));
				awaited_responses.push_back(predict_response(rq, item_key));
			end
		end

		drain();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/dbf_pkg.sv
rtl/core/dbf_key_ram.sv
rtl/core/dedup_bounded_fifo.sv
bench/dedup_bounded_fifo_test.sv
